### hdl/fpcb_pkg.sv
// Shared types, widths and constants for the frustum plane and corner builder.
package fpcb_pkg;

   localparam int unsigned QUEUE_DEPTH = 4;
   localparam int unsigned DATA_W = 32;
   localparam int unsigned THRESH_W = 16;

   localparam logic [DATA_W-1:0] SAT_POS = 32'h7fff_ffff;
   localparam logic [DATA_W-1:0] SAT_NEG = 32'h8000_0000;

   typedef struct packed {
      logic [3:0]        index;
      logic [DATA_W-1:0] value;
      logic              last;
   } load_type;

   typedef struct packed {
      logic              kind;
      logic [2:0]        index;
      logic [DATA_W-1:0] x;
      logic [DATA_W-1:0] y;
      logic [DATA_W-1:0] z;
      logic [DATA_W-1:0] w;
      logic [2:0]        sign;
      logic              valid;
      logic              last;
   } result_type;

   localparam logic KIND_PLANE  = 1'b0;
   localparam logic KIND_CORNER = 1'b1;

   function automatic logic [DATA_W-1:0] sat_mag(input logic neg, input logic [63:0] mag,
                                                 input logic over);
      logic [DATA_W-1:0] r;
      if (neg) begin
         if (over || mag > 64'h8000_0000) r = SAT_NEG;
         else r = DATA_W'(64'd0 - mag);
      end else begin
         if (over || mag > 64'h7fff_ffff) r = SAT_POS;
         else r = mag[DATA_W-1:0];
      end
      return r;
   endfunction

endpackage

### hdl/frustum_plane_corner_builder.sv
// Top level: frustum plane and corner builder.
// After the last element the fourteen results are built with the shared
// bit-serial divider (64 steps per plane term, 128 per corner coordinate)
// and the 32-step square-root loop; zero planes and degenerate corners
// finish sooner.
// Throughput: one element per cycle while the front queue has room.
// Reset: synchronous, active high; clears queues, control and threshold.
module frustum_plane_corner_builder
   import fpcb_pkg::*;
#(
   parameter int unsigned QDEPTH = QUEUE_DEPTH
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   output logic                full,
   input  logic [3:0]          req_element_index,
   input  logic signed [31:0]  req_element_value,
   input  logic                req_last_element,
   output logic                empty,
   input  logic                pop,
   output logic                rsp_result_kind,
   output logic [2:0]          rsp_result_index,
   output logic signed [31:0]  rsp_coord_x,
   output logic signed [31:0]  rsp_coord_y,
   output logic signed [31:0]  rsp_coord_z,
   output logic signed [31:0]  rsp_plane_offset,
   output logic [2:0]          rsp_sign_code,
   output logic                rsp_point_valid,
   output logic                rsp_last_result,
   input  logic                csr_write,
   input  logic [15:0]         csr_wdata
);
   logic [THRESH_W-1:0] thresh_ff;
   logic     qv, qt, rv;
   load_type qd, pd;
   result_type rd;

   always_ff @(posedge clock) begin
      if (reset) thresh_ff <= '0;
      else if (csr_write) thresh_ff <= csr_wdata;
   end

   assign pd = '{index: req_element_index, value: req_element_value,
                 last: req_last_element};

   fpcb_front #(.DEPTH(QDEPTH)) u_front (
      .clock, .reset, .push, .push_data(pd), .full,
      .q_valid(qv), .q_data(qd), .q_take(qt)
   );

   fpcb_back u_back (
      .clock, .reset, .threshold(thresh_ff), .q_valid(qv), .q_data(qd), .q_take(qt),
      .rsp_valid(rv), .rsp_data(rd), .rsp_take(pop)
   );

   assign empty            = !rv;
   assign rsp_result_kind  = rd.kind;
   assign rsp_result_index = rd.index;
   assign rsp_coord_x      = rd.x;
   assign rsp_coord_y      = rd.y;
   assign rsp_coord_z      = rd.z;
   assign rsp_plane_offset = rd.w;
   assign rsp_sign_code    = rd.sign;
   assign rsp_point_valid  = rd.valid;
   assign rsp_last_result  = rd.last;
endmodule

### hdl/fpcb_front.sv
// Front end: accepts matrix elements and queues load commands.
module fpcb_front
   import fpcb_pkg::*;
#(
   parameter int unsigned DEPTH = QUEUE_DEPTH
) (
   input  logic     clock,
   input  logic     reset,
   input  logic     push,
   input  load_type push_data,
   output logic     full,
   output logic     q_valid,
   output load_type q_data,
   input  logic     q_take
);
   localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   load_type          mem [DEPTH];
   logic [AW-1:0]     wr_ff, wr_in, rd_ff, rd_in;
   logic [AW:0]       cnt_ff, cnt_in;
   logic              do_push, do_pop;

   assign full    = (cnt_ff == (AW+1)'(DEPTH));
   assign q_valid = (cnt_ff != '0);
   assign q_data  = mem[rd_ff];
   assign do_push = push && !full;
   assign do_pop  = q_take && q_valid;

   always_comb begin
      wr_in  = wr_ff;
      rd_in  = rd_ff;
      cnt_in = cnt_ff;
      if (do_push) wr_in = (wr_ff == AW'(DEPTH-1)) ? '0 : wr_ff + 1'b1;
      if (do_pop)  rd_in = (rd_ff == AW'(DEPTH-1)) ? '0 : rd_ff + 1'b1;
      if (do_push && !do_pop) cnt_in = cnt_ff + 1'b1;
      else if (do_pop && !do_push) cnt_in = cnt_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
      if (do_push) mem[wr_ff] <= push_data;
   end
endmodule

### hdl/fpcb_divider.sv
// Shared restoring divider: unsigned 128 by 64 bits, one quotient bit per cycle.
module fpcb_divider
   import fpcb_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         start,
   input  logic [127:0] dividend,
   input  logic [63:0]  divisor,
   input  logic [7:0]   steps,
   output logic         busy,
   output logic [63:0]  quotient,
   output logic         over
);
   logic [127:0] num_ff;
   logic [63:0]  rem_ff, q_ff, dv_ff;
   logic [7:0]   cnt_ff;
   logic         over_ff, busy_ff;
   logic [64:0]  trial;
   logic [64:0]  shifted;

   assign shifted  = {rem_ff, num_ff[127]};
   assign trial    = shifted - {1'b0, dv_ff};
   assign busy     = busy_ff;
   assign quotient = q_ff;
   assign over     = over_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else if (start) begin
         busy_ff <= 1'b1;
         num_ff  <= dividend;
         dv_ff   <= divisor;
         rem_ff  <= '0;
         q_ff    <= '0;
         over_ff <= 1'b0;
         cnt_ff  <= steps;
      end else if (busy_ff) begin
         num_ff <= num_ff << 1;
         if (q_ff[63:40] != '0) over_ff <= 1'b1;
         if (!trial[64]) begin
            rem_ff <= trial[63:0];
            q_ff   <= {q_ff[62:0], 1'b1};
         end else begin
            rem_ff <= shifted[63:0];
            q_ff   <= {q_ff[62:0], 1'b0};
         end
         cnt_ff <= cnt_ff - 1'b1;
         if (cnt_ff == 8'd1) busy_ff <= 1'b0;
      end
   end
endmodule

### hdl/fpcb_back.sv
// Back end: matrix store, plane build, corner solve and result queue.
module fpcb_back
   import fpcb_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic [THRESH_W-1:0] threshold,
   input  logic                q_valid,
   input  load_type            q_data,
   output logic                q_take,
   output logic                rsp_valid,
   output result_type          rsp_data,
   input  logic                rsp_take
);
   typedef enum logic [4:0] {
      S_IDLE, S_PLOAD, S_PMAX, S_PSHIFT, S_PSQ0, S_PSQ1, S_PSQ2, S_PSQRT,
      S_PDSTART, S_PDWAIT, S_PEMIT,
      S_CLOAD, S_CCROSS, S_CDET0, S_CDET1, S_CDET2, S_CDCHK,
      S_CTERM0, S_CTERM1, S_CTERM2, S_CDSTART, S_CDWAIT, S_CEMIT
   } state_type;

   state_type state_ff;
   logic [31:0] mat [16];
   logic [31:0] pl [6][4];

   logic [2:0]  idx_ff;
   logic [1:0]  j_ff;
   logic signed [33:0] v_ff [4];
   logic [33:0] a_ff [4];
   logic [31:0] sc_ff [3];
   logic [5:0]  s_ff, t_ff;
   logic [63:0] sum_ff;
   logic [63:0] rad_ff, root_ff, bit_ff;
   logic [63:0] len_ff;
   logic [31:0] pout_ff [4];

   logic signed [31:0] n0 [4], n1 [4], n2 [4];
   logic signed [63:0] c12_ff [3], c20_ff [3], c01_ff [3];
   logic signed [65:0] det_ff;
   logic [1:0]  k_ff;
   logic signed [127:0] acc_ff;
   logic        neg_ff;
   logic [31:0] cxyz_ff [3];
   logic        cvalid_ff;

   logic         dv_start, dv_busy, dv_over;
   logic [127:0] dv_num;
   logic [63:0]  dv_den, dv_q;
   logic [7:0]   dv_steps;
   logic         dv_go_ff;

   result_type rq [4];
   logic [1:0] rw_ff, rr_ff;
   logic [2:0] rc_ff;
   logic       r_push;
   result_type r_data;

   fpcb_divider u_div (
      .clock, .reset, .start(dv_start), .dividend(dv_num), .divisor(dv_den),
      .steps(dv_steps), .busy(dv_busy), .quotient(dv_q), .over(dv_over)
   );

   assign rsp_valid = (rc_ff != '0);
   assign rsp_data  = rq[rr_ff];
   assign q_take    = (state_ff == S_IDLE) && q_valid;

   always_ff @(posedge clock) begin
      if (reset) begin
         rw_ff <= '0; rr_ff <= '0; rc_ff <= '0;
      end else begin
         if (r_push) rw_ff <= rw_ff + 1'b1;
         if (rsp_take && rsp_valid) rr_ff <= rr_ff + 1'b1;
         rc_ff <= rc_ff + 3'(r_push) - 3'(rsp_take && rsp_valid);
      end
      if (r_push) rq[rw_ff] <= r_data;
   end

   logic [33:0] m_c;
   logic [2:0]  pa, pb, pc;
   logic signed [66:0] tm_c;
   logic signed [34:0] cm_c;
   logic signed [31:0] wm_c;
   logic [63:0] dmag_c;
   logic [63:0] trial_c;

   always_comb begin
      m_c = a_ff[0];
      if (a_ff[1] > m_c) m_c = a_ff[1];
      if (a_ff[2] > m_c) m_c = a_ff[2];
      pa = idx_ff[0] ? 3'd4 : 3'd5;
      pb = idx_ff[1] ? 3'd3 : 3'd2;
      pc = idx_ff[2] ? 3'd0 : 3'd1;
      for (int r = 0; r < 4; r++) begin
         n0[r] = pl[pa][r]; n1[r] = pl[pb][r]; n2[r] = pl[pc][r];
      end
      unique case (k_ff)
         2'd0:    begin cm_c = 35'(c12_ff[j_ff]); wm_c = n0[3]; end
         2'd1:    begin cm_c = 35'(c20_ff[j_ff]); wm_c = n1[3]; end
         default: begin cm_c = 35'(c01_ff[j_ff]); wm_c = n2[3]; end
      endcase
      tm_c = 67'(cm_c) * 67'(wm_c);
      dmag_c = det_ff[65] ? 64'(-det_ff) : 64'(det_ff);
      trial_c = root_ff + bit_ff;
      dv_start = dv_go_ff;
      r_push = (state_ff == S_PEMIT || state_ff == S_CEMIT) && (rc_ff < 3'd4)
               && !(rsp_take && rsp_valid && 1'b0);
      r_data = '0;
      if (state_ff == S_PEMIT) begin
         r_data.kind = KIND_PLANE; r_data.index = idx_ff;
         r_data.x = pout_ff[0]; r_data.y = pout_ff[1];
         r_data.z = pout_ff[2]; r_data.w = pout_ff[3];
         r_data.sign = {pout_ff[2][31], pout_ff[1][31], pout_ff[0][31]};
         r_data.valid = 1'b1;
      end else begin
         r_data.kind = KIND_CORNER; r_data.index = idx_ff;
         r_data.x = cxyz_ff[0]; r_data.y = cxyz_ff[1]; r_data.z = cxyz_ff[2];
         r_data.valid = cvalid_ff; r_data.last = (idx_ff == 3'd7);
      end
   end

   logic [127:0] dnum_ff;
   logic [63:0]  dden_ff;
   logic [7:0]   dstp_ff;
   assign dv_num = dnum_ff;
   assign dv_den = dden_ff;
   assign dv_steps = dstp_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         dv_go_ff <= 1'b0;
      end else begin
         dv_go_ff <= 1'b0;
         unique case (state_ff)
            S_IDLE: if (q_valid) begin
               mat[q_data.index] <= q_data.value;
               if (q_data.last) begin idx_ff <= '0; state_ff <= S_PLOAD; end
            end
            S_PLOAD: begin
               for (int r = 0; r < 4; r++) begin
                  logic signed [33:0] c4, cc, vv;
                  c4 = 34'(signed'(mat[r*4+3]));
                  cc = 34'(signed'(mat[r*4+idx_ff[2:1]]));
                  vv = idx_ff[0] ? c4 + cc : c4 - cc;
                  v_ff[r] <= vv;
                  a_ff[r] <= vv[33] ? 34'(-vv) : vv;
               end
               state_ff <= S_PMAX;
            end
            S_PMAX: begin
               s_ff <= '0; t_ff <= '0;
               if (m_c == '0) begin
                  for (int r = 0; r < 4; r++) pout_ff[r] <= '0;
                  state_ff <= S_PEMIT;
               end else begin
                  if (m_c[33]) s_ff <= 6'd3;
                  else if (m_c[32]) s_ff <= 6'd2;
                  else if (m_c[31]) s_ff <= 6'd1;
                  else for (int b = 0; b < 31; b++) if (m_c[b]) t_ff <= 6'(30 - b);
                  state_ff <= S_PSHIFT;
               end
            end
            S_PSHIFT: begin
               for (int r = 0; r < 3; r++)
                  sc_ff[r] <= (s_ff != 0) ? 32'(a_ff[r] >> s_ff) : 32'(a_ff[r] << t_ff);
               sum_ff <= '0;
               state_ff <= S_PSQ0;
            end
            S_PSQ0: begin
               sum_ff <= 64'(sc_ff[0]) * 64'(sc_ff[0]); state_ff <= S_PSQ1;
            end
            S_PSQ1: begin
               sum_ff <= sum_ff + 64'(sc_ff[1]) * 64'(sc_ff[1]); state_ff <= S_PSQ2;
            end
            S_PSQ2: begin
               rad_ff <= sum_ff + 64'(sc_ff[2]) * 64'(sc_ff[2]);
               root_ff <= '0; bit_ff <= 64'h4000_0000_0000_0000;
               state_ff <= S_PSQRT;
            end
            S_PSQRT: begin
               if (bit_ff == '0) begin
                  len_ff <= root_ff; j_ff <= '0; state_ff <= S_PDSTART;
               end else begin
                  if (rad_ff >= trial_c) begin
                     rad_ff <= rad_ff - trial_c; root_ff <= (root_ff >> 1) + bit_ff;
                  end else root_ff <= root_ff >> 1;
                  bit_ff <= bit_ff >> 2;
               end
            end
            S_PDSTART: begin
               logic [63:0] aw;
               dden_ff <= len_ff; dstp_ff <= 8'd64;
               if (j_ff != 2'd3) begin
                  dnum_ff <= {64'(sc_ff[j_ff]) << 16, 64'd0};
                  dv_go_ff <= 1'b1; state_ff <= S_PDWAIT;
               end else begin
                  aw = (s_ff != 0) ? 64'(a_ff[3] >> s_ff) : 64'(a_ff[3]);
                  if ((aw >> (47 - ((s_ff != 0) ? 0 : t_ff))) != '0) begin
                     pout_ff[3] <= sat_mag(v_ff[3][33], '0, 1'b1);
                     state_ff <= S_PEMIT;
                  end else begin
                     dnum_ff <= {aw << (16 + ((s_ff != 0) ? 6'd0 : t_ff)), 64'd0};
                     dv_go_ff <= 1'b1; state_ff <= S_PDWAIT;
                  end
               end
            end
            S_PDWAIT: if (!dv_go_ff && !dv_busy) begin
               pout_ff[j_ff] <= sat_mag(v_ff[j_ff][33], dv_q, 1'b0);
               if (j_ff == 2'd3) state_ff <= S_PEMIT;
               else begin j_ff <= j_ff + 1'b1; state_ff <= S_PDSTART; end
            end
            S_PEMIT: if (r_push) begin
               for (int r = 0; r < 4; r++) pl[idx_ff][r] <= pout_ff[r];
               if (idx_ff == 3'd5) begin idx_ff <= '0; state_ff <= S_CLOAD; end
               else begin idx_ff <= idx_ff + 1'b1; state_ff <= S_PLOAD; end
            end
            S_CLOAD: state_ff <= S_CCROSS;
            S_CCROSS: begin
               c12_ff[0] <= n1[1]*n2[2] - n1[2]*n2[1];
               c12_ff[1] <= n1[2]*n2[0] - n1[0]*n2[2];
               c12_ff[2] <= n1[0]*n2[1] - n1[1]*n2[0];
               c20_ff[0] <= n2[1]*n0[2] - n2[2]*n0[1];
               c20_ff[1] <= n2[2]*n0[0] - n2[0]*n0[2];
               c20_ff[2] <= n2[0]*n0[1] - n2[1]*n0[0];
               c01_ff[0] <= n0[1]*n1[2] - n0[2]*n1[1];
               c01_ff[1] <= n0[2]*n1[0] - n0[0]*n1[2];
               c01_ff[2] <= n0[0]*n1[1] - n0[1]*n1[0];
               state_ff <= S_CDET0;
            end
            S_CDET0: begin
               det_ff <= 66'(n0[0]) * 66'(signed'(c12_ff[0][34:0]));
               state_ff <= S_CDET1;
            end
            S_CDET1: begin
               det_ff <= det_ff + 66'(n0[1]) * 66'(signed'(c12_ff[1][34:0]));
               state_ff <= S_CDET2;
            end
            S_CDET2: begin
               det_ff <= det_ff + 66'(n0[2]) * 66'(signed'(c12_ff[2][34:0]));
               state_ff <= S_CDCHK;
            end
            S_CDCHK: begin
               if ({2'b0, dmag_c} <= {18'd0, threshold, 32'd0}) begin
                  for (int r = 0; r < 3; r++) cxyz_ff[r] <= '0;
                  cvalid_ff <= 1'b0; state_ff <= S_CEMIT;
               end else begin
                  cvalid_ff <= 1'b1; j_ff <= '0; k_ff <= '0; acc_ff <= '0;
                  state_ff <= S_CTERM0;
               end
            end
            S_CTERM0, S_CTERM1, S_CTERM2: begin
               acc_ff <= acc_ff + 128'(tm_c);
               k_ff <= k_ff + 1'b1;
               if (k_ff == 2'd2) state_ff <= S_CDSTART;
            end
            S_CDSTART: begin
               logic [127:0] mag;
               mag = acc_ff[127] ? 128'(-acc_ff) : 128'(acc_ff);
               neg_ff <= acc_ff[127] == det_ff[65];
               dnum_ff <= mag << 16; dden_ff <= dmag_c; dstp_ff <= 8'd128;
               dv_go_ff <= 1'b1; state_ff <= S_CDWAIT;
            end
            S_CDWAIT: if (!dv_go_ff && !dv_busy) begin
               cxyz_ff[j_ff] <= sat_mag(neg_ff, dv_q, dv_over);
               if (j_ff == 2'd2) state_ff <= S_CEMIT;
               else begin
                  j_ff <= j_ff + 1'b1; k_ff <= '0; acc_ff <= '0; state_ff <= S_CTERM0;
               end
            end
            S_CEMIT: if (r_push) begin
               if (idx_ff == 3'd7) state_ff <= S_IDLE;
               else begin idx_ff <= idx_ff + 1'b1; state_ff <= S_CLOAD; end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end
endmodule

### hdl/fpcb_checker.sv
// Port-level checker for the frustum plane and corner builder, with its bind.
module fpcb_checker (
   input logic        clock,
   input logic        reset,
   input logic        empty,
   input logic        pop,
   input logic        rsp_result_kind,
   input logic [2:0]  rsp_result_index,
   input logic [2:0]  rsp_sign_code,
   input logic        rsp_point_valid,
   input logic        rsp_last_result,
   input logic [31:0] rsp_plane_offset
);
   a_plane_valid: assert property (@(posedge clock) disable iff (reset)
      !empty && !rsp_result_kind |-> rsp_point_valid && !rsp_last_result)
      else $error("plane result not valid or marked last");
   a_corner_zero: assert property (@(posedge clock) disable iff (reset)
      !empty && rsp_result_kind |-> rsp_plane_offset == 0 && rsp_sign_code == 0)
      else $error("corner carries plane fields");
   a_last_idx: assert property (@(posedge clock) disable iff (reset)
      !empty && rsp_last_result |-> rsp_result_kind && rsp_result_index == 3'd7)
      else $error("last flag on wrong result");
   a_hold: assert property (@(posedge clock) disable iff (reset)
      !empty && !pop |=> !empty && $stable(rsp_result_index))
      else $error("waiting result changed");
endmodule

bind frustum_plane_corner_builder fpcb_checker u_chk (
   .clock, .reset, .empty, .pop, .rsp_result_kind, .rsp_result_index,
   .rsp_sign_code, .rsp_point_valid, .rsp_last_result, .rsp_plane_offset
);
